// ===== sv/mrlf_pkg.sv =====
// Package for the modem response line filter: line classes, match-string
// constants, the matcher request struct and the string compare helpers.
// Depends on nothing; used by mrlf_match and modem_response_line_filter.
package mrlf_pkg;

   typedef enum logic [2:0] {
      CLS_FORWARD   = 3'd0,
      CLS_STARTUP   = 3'd1,
      CLS_PBREADY   = 3'd2,
      CLS_RING      = 3'd3,
      CLS_NOCARRIER = 3'd4,
      CLS_NEWMSG    = 3'd5
   } line_class_type;

   // Strings that must match the whole line.
   typedef enum logic [1:0] {
      EXACT_STARTUP   = 2'd0,
      EXACT_PBREADY   = 2'd1,
      EXACT_RING      = 2'd2,
      EXACT_NOCARRIER = 2'd3
   } exact_id_type;

   localparam int NUM_EXACT = 4;

   localparam int LEN_STARTUP   = 13;
   localparam int LEN_PBREADY   = 8;
   localparam int LEN_RING      = 4;
   localparam int LEN_NOCARRIER = 10;
   localparam int LEN_NEWMSG    = 11;

   // First character sits in the top byte.
   localparam logic [8*LEN_STARTUP-1:0]   TXT_STARTUP   = "MODEM:STARTUP";
   localparam logic [8*LEN_PBREADY-1:0]   TXT_PBREADY   = "+PBREADY";
   localparam logic [8*LEN_RING-1:0]      TXT_RING      = "RING";
   localparam logic [8*LEN_NOCARRIER-1:0] TXT_NOCARRIER = "NO CARRIER";
   localparam logic [8*LEN_NEWMSG-1:0]    TXT_NEWMSG    = "+CMTI: \"SM\"";

   // Request from the line assembler to the matcher.
   typedef struct packed {
      logic       push;   // byte appended this cycle
      logic       clear;  // line closes this cycle
      logic [3:0] pos;    // fill count, saturated at 15
      logic [6:0] ch;     // appended byte
   } match_req_type;

   function automatic logic [4:0] exact_len(exact_id_type id);
      logic [4:0] len;
      len = '0;
      unique case (id)
         EXACT_STARTUP:   len = 5'(LEN_STARTUP);
         EXACT_PBREADY:   len = 5'(LEN_PBREADY);
         EXACT_RING:      len = 5'(LEN_RING);
         EXACT_NOCARRIER: len = 5'(LEN_NOCARRIER);
      endcase
      return len;
   endfunction

   // Character at a position; zero past the end (never equal to a stored byte).
   function automatic logic [6:0] exact_char(exact_id_type id, logic [3:0] pos);
      logic [7:0] ch;
      int         p;
      ch = '0;
      p  = int'(pos);
      unique case (id)
         EXACT_STARTUP: begin
            if (p < LEN_STARTUP) ch = TXT_STARTUP[8*(LEN_STARTUP-1-p) +: 8];
         end
         EXACT_PBREADY: begin
            if (p < LEN_PBREADY) ch = TXT_PBREADY[8*(LEN_PBREADY-1-p) +: 8];
         end
         EXACT_RING: begin
            if (p < LEN_RING) ch = TXT_RING[8*(LEN_RING-1-p) +: 8];
         end
         EXACT_NOCARRIER: begin
            if (p < LEN_NOCARRIER) ch = TXT_NOCARRIER[8*(LEN_NOCARRIER-1-p) +: 8];
         end
      endcase
      return ch[6:0];
   endfunction

   // Window holds the newest byte in the low slot.
   function automatic logic newmsg_hit(logic [7*LEN_NEWMSG-1:0] win);
      logic hit;
      hit = 1'b1;
      for (int k = 0; k < LEN_NEWMSG; k++) begin
         if (win[7*k +: 7] != TXT_NEWMSG[8*k +: 7]) hit = 1'b0;
      end
      return hit;
   endfunction

endpackage

// ===== sv/mrlf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the line store of the filter.
module mrlf_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 63,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/mrlf_match.sv =====
// Running line classifier: tracks exact-match prefixes and a sliding window
// for the new-message notice as bytes are appended. Depends on mrlf_pkg.
module mrlf_match (
   input  logic                    clock,
   input  logic                    reset,
   input  mrlf_pkg::match_req_type req,
   output mrlf_pkg::line_class_type line_class
);

   localparam int WW = 7 * mrlf_pkg::LEN_NEWMSG;

   logic [mrlf_pkg::NUM_EXACT-1:0] ok_ff, ok_in, ok_upd, eq;
   logic [WW-1:0]                  win_ff, win_in, win_shift;
   logic                           found_ff, found_in, found_upd;
   logic [4:0]                     len_after;
   mrlf_pkg::exact_id_type         id;

   always_comb begin
      len_after = {1'b0, req.pos} + 5'(req.push);
      win_shift = {win_ff[WW-8:0], req.ch};
      found_upd = found_ff | (req.push & mrlf_pkg::newmsg_hit(win_shift));
      id        = mrlf_pkg::EXACT_STARTUP;
      for (int i = 0; i < mrlf_pkg::NUM_EXACT; i++) begin
         id        = mrlf_pkg::exact_id_type'(i);
         ok_upd[i] = ok_ff[i] &
                     (~req.push | (mrlf_pkg::exact_char(id, req.pos) == req.ch));
         eq[i]     = ok_upd[i] & (len_after == mrlf_pkg::exact_len(id));
      end

      // exact strings win over the substring test, in list order
      priority if (eq[mrlf_pkg::EXACT_STARTUP])   line_class = mrlf_pkg::CLS_STARTUP;
      else if (eq[mrlf_pkg::EXACT_PBREADY])       line_class = mrlf_pkg::CLS_PBREADY;
      else if (eq[mrlf_pkg::EXACT_RING])          line_class = mrlf_pkg::CLS_RING;
      else if (eq[mrlf_pkg::EXACT_NOCARRIER])     line_class = mrlf_pkg::CLS_NOCARRIER;
      else if (found_upd)                         line_class = mrlf_pkg::CLS_NEWMSG;
      else                                        line_class = mrlf_pkg::CLS_FORWARD;

      if (req.clear) begin
         ok_in    = '1;
         win_in   = '0;
         found_in = 1'b0;
      end else begin
         ok_in    = ok_upd;
         win_in   = req.push ? win_shift : win_ff;
         found_in = found_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ok_ff    <= '1;
         win_ff   <= '0;  // zero never matches a printable character
         found_ff <= 1'b0;
      end else begin
         ok_ff    <= ok_in;
         win_ff   <= win_in;
         found_ff <= found_in;
      end
   end

endmodule

// ===== sv/modem_response_line_filter.sv =====
// Modem response line filter: top level. Instantiates mrlf_ram (line store)
// and mrlf_match (classifier); uses mrlf_pkg for classes and strings.
//
// Received modem bytes enter one per transfer on req_ and are built into
// lines. A '>' on an empty line closes at once as the one-byte line ">". A
// space on an empty line and any non-printable byte on an empty line are
// dropped; other printable bytes (0x20..0x7E) are appended. A non-printable
// byte closes a non-empty line, and the byte that brings the line to
// LINE_CAPACITY-1 bytes closes it too. A closed line goes out on rsp_ one
// byte per transfer, in order, with last_byte on its final byte and the
// line's class and flags on every byte: startup, phonebook ready, ring and
// no carrier need an exact whole-line match (tested in that order), new
// message needs +CMTI: "SM" anywhere in the line, anything else is forwarded.
// A byte that closes a line of n bytes is followed by a drain of its n bytes
// (longer if rsp_stall is held), during which req_stall is high; the drain
// reads one line-store entry per cycle while rsp_stall is low, through the
// RAM's single read port, and the next byte is taken in the cycle after the
// last byte's transfer. No clearing pass after reset: only entries written
// for the current line are ever read.
module modem_response_line_filter #(
   parameter int LINE_CAPACITY = 64
) (
   input  logic       clock,
   input  logic       reset,
   // received bytes
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // line bytes out
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_line_byte,
   output logic       rsp_last_byte,
   output logic [2:0] rsp_line_class,
   output logic       rsp_modem_not_ready,
   output logic       rsp_wakeup_init
);

   localparam int DEPTH = LINE_CAPACITY - 1;   // store entries
   localparam int AW    = $clog2(DEPTH);       // store index
   localparam int CW    = $clog2(DEPTH + 1);   // fill count incl. full

   localparam logic [7:0] CH_PROMPT   = 8'h3E;  // '>'
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_PRINT_LO = 8'h20;
   localparam logic [7:0] CH_PRINT_HI = 8'h7E;

   typedef enum logic {
      ST_IDLE,   // collecting bytes
      ST_DRAIN   // sending out a closed line
   } state_type;

   state_type                state_ff, state_in;
   logic [AW-1:0]            fill_ff, fill_in;       // bytes in current line
   logic [AW-1:0]            idx_ff, idx_in;         // drain position
   logic [AW-1:0]            last_idx_ff, last_idx_in;
   mrlf_pkg::line_class_type cls_ff, cls_in;
   logic                     fwd_hit_ff, fwd_hit_in; // read-during-write bypass
   logic [6:0]               fwd_data_ff, fwd_data_in;

   logic                     req_take, rsp_take;
   logic                     printable, is_prompt, store, close;
   logic [CW-1:0]            fill_after;
   logic                     wr_en;
   logic [6:0]               rd_data;
   mrlf_pkg::match_req_type  mreq;
   mrlf_pkg::line_class_type match_class;

   // -------------------------------------------------------------------
   // Input side: decide store / close for the byte being transferred
   // -------------------------------------------------------------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      printable  = (req_rx_byte >= CH_PRINT_LO) && (req_rx_byte <= CH_PRINT_HI);
      is_prompt  = (req_rx_byte == CH_PROMPT) && (fill_ff == '0);
      // leading space is dropped; the prompt is stored like any other byte
      store      = printable && !((req_rx_byte == CH_SPACE) && (fill_ff == '0));
      fill_after = CW'(fill_ff) + CW'(store);
      close      = is_prompt
                   || (store && (fill_after == CW'(DEPTH)))
                   || (!printable && (fill_ff != '0));
      wr_en      = req_take & store;

      mreq.push  = wr_en;
      mreq.clear = req_take & close;
      mreq.pos   = (fill_ff > AW'(15)) ? 4'd15 : fill_ff[3:0];
      mreq.ch    = req_rx_byte[6:0];
   end

   // -------------------------------------------------------------------
   // Next-state logic
   // -------------------------------------------------------------------
   assign rsp_valid = (state_ff == ST_DRAIN);
   assign rsp_take  = rsp_valid & ~rsp_stall;

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      idx_in      = idx_ff;
      last_idx_in = last_idx_ff;
      cls_in      = cls_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (close) begin
                  state_in    = ST_DRAIN;
                  fill_in     = '0;
                  idx_in      = '0;
                  last_idx_in = AW'(fill_after - CW'(1));
                  cls_in      = match_class;
               end else if (store) begin
                  fill_in = fill_after[AW-1:0];
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_take) begin
               if (idx_ff == last_idx_ff) begin
                  state_in = ST_IDLE;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + AW'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // RAM reads idx_in, so its registered output always shows entry idx_ff.
      // A prompt writes entry 0 in the cycle that entry 0 is read: bypass.
      fwd_hit_in  = wr_en && (fill_ff == idx_in);
      fwd_data_in = req_rx_byte[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         idx_ff      <= '0;
         last_idx_ff <= '0;
         cls_ff      <= mrlf_pkg::CLS_FORWARD;
         fwd_hit_ff  <= 1'b0;
         fwd_data_ff <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         idx_ff      <= idx_in;
         last_idx_ff <= last_idx_in;
         cls_ff      <= cls_in;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= fwd_data_in;
      end
   end

   // -------------------------------------------------------------------
   // Line store and classifier
   // -------------------------------------------------------------------
   mrlf_ram #(
      .WIDTH (7),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (req_rx_byte[6:0]),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   mrlf_match u_match (
      .clock      (clock),
      .reset      (reset),
      .req        (mreq),
      .line_class (match_class)
   );

   // -------------------------------------------------------------------
   // Result fields
   // -------------------------------------------------------------------
   assign rsp_line_byte       = fwd_hit_ff ? fwd_data_ff : rd_data;
   assign rsp_last_byte       = (idx_ff == last_idx_ff);
   assign rsp_line_class      = cls_ff;
   assign rsp_modem_not_ready = (cls_ff == mrlf_pkg::CLS_STARTUP)
                                || (cls_ff == mrlf_pkg::CLS_PBREADY);
   assign rsp_wakeup_init     = (cls_ff == mrlf_pkg::CLS_PBREADY);

   // -------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------
   // transfer of the last byte ends the line
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_byte |=> !rsp_valid)
      else $error("line continued after last byte");

   // a line never ends without its last byte going out
   a_no_early_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_byte |=> rsp_valid)
      else $error("line drain ended early");

   // drain index stays within the closed line
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> idx_ff <= last_idx_ff)
      else $error("drain index past end of line");

   // no byte enters the store while a line is being drained
   a_no_write_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> !wr_en && fill_ff == '0)
      else $error("store written during drain");

endmodule
